[rtl/cnos_pkg.sv]
`default_nettype none

package cnos_pkg;

	localparam int COUNT_BITS  = 24;
	localparam int OFFSET_BITS = 40;
	localparam int DATA_BITS   = 32;
	localparam int SQ_BITS     = 2 * COUNT_BITS;
	localparam int STEP_BITS   = $clog2(DATA_BITS);

	// divider trial width: holds the shifted partial remainder and the widest divisor
	localparam int DIV_W = ((SQ_BITS > DATA_BITS) ? SQ_BITS : DATA_BITS) + 2;

	// stream payload layout, lowest field first
	localparam int IN_FIELD_BITS  = COUNT_BITS + 2 * DATA_BITS;
	localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = 2 * OFFSET_BITS + 2 * DATA_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

	localparam int IN_SIG_LSB  = COUNT_BITS;
	localparam int IN_ERR_LSB  = COUNT_BITS + DATA_BITS;
	localparam int OUT_MEAN_LSB  = OFFSET_BITS;
	localparam int OUT_SCALE_LSB = OFFSET_BITS + DATA_BITS;
	localparam int OUT_TOTAL_LSB = OFFSET_BITS + 2 * DATA_BITS;

endpackage

`default_nettype wire

[rtl/cell_normalize_offset_scan.sv]
// Cell normalize and offset scan.
// Input stream s_*: one histogram cell per transfer, tlast marks the last
// cell of an image. Output stream m_*: one result per cell, in order, with
// tlast copied from the cell. Each result carries the exclusive running
// pixel offset, the mean signal (signal / count), the scaled error
// (error / count^2), and the inclusive running total; offsets saturate.
// A cell with zero count passes signal and error through unchanged.
// Timing: a cell with nonzero count passes through the divider before its
// result is offered (one restoring divider step per cycle, 32 steps for
// the signal, then 32 for the error, on one shared subtract/compare unit);
// a zero-count cell skips the divider. s_tready is high only in the idle
// state, so a new cell is taken only once the last result has moved into
// the output register. The result sits in an output register, so the
// next cell is taken while a result waits; a stalled receiver holds the
// finished quotients until the output register frees.
// Reset clears the running offset and empties both sides; the offset also
// returns to zero after each tlast cell.
`default_nettype none

module cell_normalize_offset_scan (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// pixel_count, signal_sum, error_sum
	input  wire  [cnos_pkg::IN_TDATA_BITS-1:0] s_tdata,
	input  wire                                s_tlast,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// chunk_start, mean_signal, scaled_error, pixel_total
	output logic [cnos_pkg::OUT_TDATA_BITS-1:0] m_tdata,
	output logic                               m_tlast
);
	import cnos_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SIG  = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(DATA_BITS - 1);

	logic [1:0]             state_q;
	logic [STEP_BITS-1:0]   cnt_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [OFFSET_BITS-1:0] start_q;
	logic [OFFSET_BITS-1:0] total_q;
	logic                   last_q;
	logic                   neg_q;
	logic [DATA_BITS-1:0]   err_q;
	logic [SQ_BITS-1:0]     sq_q;
	logic [SQ_BITS-1:0]     div_q;
	logic [DATA_BITS-1:0]   rem_q;
	logic [DATA_BITS-1:0]   quo_q;
	logic [DATA_BITS-1:0]   mean_q;
	logic [DATA_BITS-1:0]   scaled_q;

	logic [COUNT_BITS-1:0]  in_count;
	logic [DATA_BITS-1:0]   in_sig;
	logic [DATA_BITS-1:0]   in_err;
	logic                   in_xfer;
	logic                   out_free;
	logic [OFFSET_BITS:0]   sum;
	logic [OFFSET_BITS-1:0] total;
	logic [DATA_BITS-1:0]   sig_mag;
	logic [DIV_W-1:0]       trial;
	logic                   ge;
	logic [DATA_BITS-1:0]   rem_n;
	logic [DATA_BITS-1:0]   quo_n;
	logic [DATA_BITS-1:0]   mean_n;
	logic [OUT_TDATA_BITS-1:0] out_word;

	assign in_count = s_tdata[COUNT_BITS-1:0];
	assign in_sig   = s_tdata[IN_SIG_LSB +: DATA_BITS];
	assign in_err   = s_tdata[IN_ERR_LSB +: DATA_BITS];

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	// saturating offset add
	assign sum   = (OFFSET_BITS + 1)'(off_q) + (OFFSET_BITS + 1)'(in_count);
	assign total = sum[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : sum[OFFSET_BITS-1:0];

	assign sig_mag = in_sig[DATA_BITS-1] ? (~in_sig + 1'b1) : in_sig;

	// shared restoring divider step
	assign trial = DIV_W'({rem_q, quo_q[DATA_BITS-1]}) - DIV_W'(div_q);
	assign ge    = !trial[DIV_W-1];
	assign rem_n = ge ? trial[DATA_BITS-1:0] : {rem_q[DATA_BITS-2:0], quo_q[DATA_BITS-1]};
	assign quo_n = {quo_q[DATA_BITS-2:0], ge};
	assign mean_n = neg_q ? (~quo_n + 1'b1) : quo_n;

	always_comb begin
		out_word = '0;
		out_word[OFFSET_BITS-1:0]             = start_q;
		out_word[OUT_MEAN_LSB +: DATA_BITS]   = mean_q;
		out_word[OUT_SCALE_LSB +: DATA_BITS]  = scaled_q;
		out_word[OUT_TOTAL_LSB +: OFFSET_BITS] = total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			off_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			// load a finished cell, else drop valid once its transfer completes
			if (state_q == ST_DONE && out_free)
				m_tvalid <= 1'b1;
			else if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						off_q <= s_tlast ? '0 : total;
						cnt_q <= '0;
						state_q <= (in_count == '0) ? ST_DONE : ST_SIG;
					end
				end
				ST_SIG: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_LAST)
						state_q <= ST_ERR;
				end
				ST_ERR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_LAST)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					start_q  <= off_q;
					total_q  <= total;
					last_q   <= s_tlast;
					neg_q    <= in_sig[DATA_BITS-1];
					err_q    <= in_err;
					sq_q     <= SQ_BITS'(in_count) * SQ_BITS'(in_count);
					div_q    <= SQ_BITS'(in_count);
					rem_q    <= '0;
					quo_q    <= sig_mag;
					mean_q   <= in_sig;
					scaled_q <= in_err;
				end
			end
			ST_SIG: begin
				if (cnt_q == STEP_LAST) begin
					// hand the divider over to the error quotient
					mean_q <= mean_n;
					div_q  <= sq_q;
					rem_q  <= '0;
					quo_q  <= err_q;
				end else begin
					rem_q <= rem_n;
					quo_q <= quo_n;
				end
			end
			ST_ERR: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				if (cnt_q == STEP_LAST)
					scaled_q <= quo_n;
			end
			ST_DONE: begin
				if (out_free) begin
					m_tdata <= out_word;
					m_tlast <= last_q;
				end
			end
			default: ;
		endcase
	end

	a_idle_step_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cnt_q == '0))
		else $error("step counter not cleared while idle");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_SIG || state_q == ST_DONE))
		else $error("accepted cell did not start work");

	a_err_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ERR && cnt_q == STEP_LAST) |=> (state_q == ST_DONE))
		else $error("error division did not finish");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIG || state_q == ST_ERR) |-> (DIV_W'(rem_q) < DIV_W'(div_q)))
		else $error("partial remainder not below divisor");

	a_offset_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> (off_q == '0))
		else $error("offset not restarted after last cell");

endmodule

`default_nettype wire

[tb/cell_normalize_offset_scan_tb.sv]
module cell_normalize_offset_scan_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cnos_pkg::*;

	localparam int IDLE_LIMIT   = 4000;
	localparam int RANDOM_CELLS = 1900;
	localparam int BACKLOG_HOLD = 400;

	typedef struct packed {
		logic [COUNT_BITS-1:0] count;
		logic [DATA_BITS-1:0]  signal;
		logic [DATA_BITS-1:0]  error;
		logic                  last;
	} cell_t;

	typedef struct packed {
		logic [OFFSET_BITS-1:0] chunk_start;
		logic [DATA_BITS-1:0]   mean_signal;
		logic [DATA_BITS-1:0]   scaled_error;
		logic [OFFSET_BITS-1:0] pixel_total;
		logic                   end_of_image;
	} norm_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	wire                       s_tready;
	// pixel_count, signal_sum, error_sum
	logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
	logic                      s_tlast = 1'b0;
	wire                       m_tvalid;
	logic                      m_tready = 1'b0;
	// chunk_start, mean_signal, scaled_error, pixel_total
	wire  [OUT_TDATA_BITS-1:0] m_tdata;
	wire                       m_tlast;

	cell_normalize_offset_scan dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	// predictor state: chunk start of the next cell
	logic [OFFSET_BITS-1:0] pix_offset = '0;
	norm_result_t           norm_queue[$];

	int mismatches    = 0;
	int cells_sent    = 0;
	int images_closed = 0;
	int zero_cells    = 0;
	int neg_signals   = 0;
	int results_seen  = 0;
	int burst_left    = 0;
	bit steady_send   = 1'b0;
	int hold_req      = 0;
	int idle_cycles   = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic norm_result_t normalize_cell(cell_t c);
		norm_result_t       r;
		logic [OFFSET_BITS:0] sum;
		longint             quot;
		longint unsigned    square;
		r.chunk_start = pix_offset;
		sum = {1'b0, pix_offset} + (OFFSET_BITS+1)'(c.count);
		r.pixel_total = sum[OFFSET_BITS] ? '1 : sum[OFFSET_BITS-1:0];
		r.mean_signal = c.signal;
		r.scaled_error = c.error;
		if (c.count != 0) begin
			// signed divide truncates toward zero
			quot = longint'($signed(c.signal)) / longint'(c.count);
			r.mean_signal = quot[DATA_BITS-1:0];
			square = longint'(c.count) * longint'(c.count);
			quot = longint'(longint'(c.error) / square);
			r.scaled_error = quot[DATA_BITS-1:0];
		end
		r.end_of_image = c.last;
		pix_offset = c.last ? '0 : r.pixel_total;
		return r;
	endfunction

	function automatic logic [COUNT_BITS-1:0] rand_count();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return COUNT_BITS'(1);
			2: return COUNT_BITS'($urandom());
			3: return '1 - COUNT_BITS'($urandom_range(0, 3));
			4, 5, 6: return COUNT_BITS'($urandom_range(1, 300));
			default: return COUNT_BITS'($urandom() >> $urandom_range(8, 31));
		endcase
	endfunction

	function automatic logic [DATA_BITS-1:0] rand_signal();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000 + $urandom_range(0, 3);
			1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			2: return DATA_BITS'($signed($urandom_range(0, 2000)) - 1000);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [DATA_BITS-1:0] rand_error();
		case ($urandom_range(0, 4))
			0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			1: return $urandom_range(0, 5000);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_cell(input logic [COUNT_BITS-1:0] count,
			input logic [DATA_BITS-1:0] signal, input logic [DATA_BITS-1:0] error,
			input logic last);
		cell_t c;
		int    gap;
		if (!steady_send && burst_left == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: gap = 0;
				4, 5, 6, 7: gap = $urandom_range(1, 8);
				default: gap = $urandom_range(9, 90);
			endcase
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		c = '{count: count, signal: signal, error: error, last: last};
		s_tvalid <= 1'b1;
		s_tdata <= {error, signal, count};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		norm_queue = {norm_queue, normalize_cell(c)};
		cells_sent++;
		if (last)
			images_closed++;
		if (count == 0)
			zero_cells++;
		if (signal[DATA_BITS-1])
			neg_signals++;
	endtask

	task automatic send_random_cell(input logic last);
		send_cell(rand_count(), rand_signal(), rand_error(), last);
	endtask

	// drop valid and hold until every pending result has come back
	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		while (norm_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_cell(24'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_cell(24'd0, 32'h8000_0000, 32'h0, 1'b0);
		send_cell(24'd1, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
		send_cell(24'd1, 32'h7FFF_FFFF, 32'h1, 1'b0);
		send_cell(24'd2, -32'sd3, 32'd7, 1'b0);
		send_cell(24'd3, -32'sd7, 32'd100, 1'b0);
		send_cell(24'd7, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
		send_cell('1, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
		send_cell(24'h00FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_cell(24'h010000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		// small negative over a large count must round to zero
		send_cell('1, 32'hFFFF_FFFF, 32'h0, 1'b1);
		send_cell(24'd5, 32'd10, 32'd25, 1'b1);
		send_cell(24'd0, 32'hFFFF_FFFF, 32'd5, 1'b1);
		send_cell(24'hAAAAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
		send_cell(24'h555555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
		send_cell(24'h800000, 32'hFFFF_0000, 32'h0001_0000, 1'b1);
		send_cell('1, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
		send_cell('1, 32'h0000_0000, 32'h0000_0000, 1'b1);
		wait_results_done();
	endtask

	// receiver holds off while the sender keeps offering, filling the block
	task automatic test_output_backlog();
		steady_send = 1'b1;
		hold_req = BACKLOG_HOLD;
		for (int i = 0; i < 12; i++)
			send_random_cell(i == 11);
		steady_send = 1'b0;
		wait_results_done();
	endtask

	task automatic test_random_images();
		int len;
		int sent;
		sent = 0;
		while (sent < RANDOM_CELLS) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
			for (int i = 0; i < len; i++) begin
				// an occasional early end breaks the image short
				send_random_cell(i == len - 1 || $urandom_range(0, 99) < 3);
				sent++;
			end
			if ($urandom_range(0, 15) == 0)
				wait_results_done();
		end
		wait_results_done();
	endtask

	task automatic test_sender_pause();
		for (int i = 0; i < 6; i++)
			send_random_cell(1'b0);
		wait_results_done();
		for (int i = 0; i < 6; i++)
			send_random_cell(i == 5);
		wait_results_done();
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		norm_result_t got;
		norm_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.chunk_start = m_tdata[OFFSET_BITS-1:0];
			got.mean_signal = m_tdata[OUT_MEAN_LSB +: DATA_BITS];
			got.scaled_error = m_tdata[OUT_SCALE_LSB +: DATA_BITS];
			got.pixel_total = m_tdata[OUT_TOTAL_LSB +: OFFSET_BITS];
			got.end_of_image = m_tlast;
			results_seen++;
			if (norm_queue.size() == 0) begin
				$error("result transfer with no cell pending");
				mismatches++;
			end else begin
				want = norm_queue.pop_front();
				compare_field("chunk_start", 64'(want.chunk_start), 64'(got.chunk_start));
				compare_field("mean_signal", 64'(want.mean_signal), 64'(got.mean_signal));
				compare_field("scaled_error", 64'(want.scaled_error),
					64'(got.scaled_error));
				compare_field("pixel_total", 64'(want.pixel_total), 64'(got.pixel_total));
				compare_field("end_of_image", 64'(want.end_of_image),
					64'(got.end_of_image));
			end
		end
	end

	// receiver: segments of different stall density, plus requested hold-offs
	always @(posedge clk) begin : receiver
		static int seg_left  = 0;
		static int stall_pct = 0;
		static int hold_left = 0;
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (seg_left == 0) begin
			seg_left = $urandom_range(20, 300);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 25;
				2: stall_pct = 60;
				default: stall_pct = 90;
			endcase
		end
		seg_left--;
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_output_backlog();
		test_random_images();
		test_sender_pause();
		s_tvalid <= 1'b0;
		while (norm_queue.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (norm_queue.size() != 0) begin
			$error("%0d results never arrived", norm_queue.size());
			mismatches++;
		end
		$display("cells sent %0d in %0d images, %0d with zero count, %0d negative signals",
			cells_sent, images_closed, zero_cells, neg_signals);
		$display("results checked %0d, including a long output backlog and sender pauses",
			results_seen);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
